[hw/rtl/mbe_pkg.sv]
package mbe_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;
    localparam int PIXEL_BITS = 12;
    localparam int DIM_BITS   = 13;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic signed [2*COORD_BITS-1:0] prod_t;

    localparam coord_t MAX_COORD = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t MIN_COORD = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Escape threshold 4.0 in the fixed-point format, one bit wider than a coordinate.
    localparam logic [COORD_BITS:0] ESCAPE_LIMIT = (COORD_BITS+1)'(4) << FRAC_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WIN_LEFT       = 3'd0,
        REG_WIN_BOTTOM     = 3'd1,
        REG_STEP_X         = 3'd2,
        REG_STEP_Y         = 3'd3,
        REG_MAX_ITERATIONS = 3'd4,
        REG_IMAGE_WIDTH    = 3'd5,
        REG_IMAGE_HEIGHT   = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_x;
        logic [PIXEL_BITS-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [ITER_BITS-1:0] iteration_count;
        logic                 in_range;
    } pixel_out_t;

    typedef struct packed {
        coord_t               win_left;
        coord_t               win_bottom;
        coord_t               step_x;
        coord_t               step_y;
        logic [ITER_BITS-1:0] max_iterations;
        logic [DIM_BITS-1:0]  image_width;
        logic [DIM_BITS-1:0]  image_height;
    } cfg_t;

    localparam coord_t               RST_WIN_LEFT   = -coord_t'(536870912);
    localparam coord_t               RST_WIN_BOTTOM = -coord_t'(536870912);
    localparam coord_t               RST_STEP_X     = coord_t'(1048576);
    localparam coord_t               RST_STEP_Y     = coord_t'(1048576);
    localparam logic [ITER_BITS-1:0] RST_MAX_ITER   = ITER_BITS'(256);
    localparam logic [DIM_BITS-1:0]  RST_WIDTH      = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]  RST_HEIGHT     = DIM_BITS'(480);

    // Clamp a double-width value into the coordinate range.
    function automatic coord_t clamp_prod(prod_t v);
        logic [COORD_BITS:0] top;
        top = v[2*COORD_BITS-1:COORD_BITS-1];
        if ((&top) || !(|top)) begin
            return v[COORD_BITS-1:0];
        end
        return v[2*COORD_BITS-1] ? MIN_COORD : MAX_COORD;
    endfunction

    function automatic coord_t clamp_sum(logic signed [COORD_BITS:0] s);
        if (s[COORD_BITS] != s[COORD_BITS-1]) begin
            return s[COORD_BITS] ? MIN_COORD : MAX_COORD;
        end
        return s[COORD_BITS-1:0];
    endfunction

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
        return clamp_sum(s);
    endfunction

    function automatic coord_t sat_sub(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        s = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return clamp_sum(s);
    endfunction

endpackage

[hw/rtl/mbe_cfg_regs.sv]
module mbe_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output mbe_pkg::cfg_t                        cfg
);

    mbe_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_left       <= mbe_pkg::RST_WIN_LEFT;
            cfg_reg.win_bottom     <= mbe_pkg::RST_WIN_BOTTOM;
            cfg_reg.step_x         <= mbe_pkg::RST_STEP_X;
            cfg_reg.step_y         <= mbe_pkg::RST_STEP_Y;
            cfg_reg.max_iterations <= mbe_pkg::RST_MAX_ITER;
            cfg_reg.image_width    <= mbe_pkg::RST_WIDTH;
            cfg_reg.image_height   <= mbe_pkg::RST_HEIGHT;
        end else if (cfg_valid) begin
            unique case (mbe_pkg::reg_index_t'(cfg_index))
                mbe_pkg::REG_WIN_LEFT: begin
                    cfg_reg.win_left <= cfg_data[mbe_pkg::COORD_BITS-1:0];
                end
                mbe_pkg::REG_WIN_BOTTOM: begin
                    cfg_reg.win_bottom <= cfg_data[mbe_pkg::COORD_BITS-1:0];
                end
                mbe_pkg::REG_STEP_X: begin
                    cfg_reg.step_x <= cfg_data[mbe_pkg::COORD_BITS-1:0];
                end
                mbe_pkg::REG_STEP_Y: begin
                    cfg_reg.step_y <= cfg_data[mbe_pkg::COORD_BITS-1:0];
                end
                mbe_pkg::REG_MAX_ITERATIONS: begin
                    cfg_reg.max_iterations <= cfg_data[mbe_pkg::ITER_BITS-1:0];
                end
                mbe_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_data[mbe_pkg::DIM_BITS-1:0];
                end
                mbe_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= cfg_data[mbe_pkg::DIM_BITS-1:0];
                end
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

endmodule

[hw/rtl/mbe_mul.sv]
module mbe_mul (
    input  logic                aclk,
    input  mbe_pkg::coord_t     op_a,
    input  mbe_pkg::coord_t     op_b,
    output mbe_pkg::prod_t      prod
);

    mbe_pkg::prod_t prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mbe_pkg::prod_t'(op_a) * mbe_pkg::prod_t'(op_b);
    end

endmodule

[hw/rtl/mbe_seq.sv]
module mbe_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mbe_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbe_pkg::pixel_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbe_pkg::pixel_out_t  m_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CX,
        S_CY,
        S_CYW,
        S_XY,
        S_UPD,
        S_SQX,
        S_SQY,
        S_CHK,
        S_FIN
    } state_t;

    state_t                                state_reg;
    logic [mbe_pkg::PIXEL_BITS-1:0]        px_reg;
    logic [mbe_pkg::PIXEL_BITS-1:0]        py_reg;
    logic [mbe_pkg::ITER_BITS-1:0]         limit_reg;
    logic [mbe_pkg::ITER_BITS-1:0]         iter_reg;
    mbe_pkg::coord_t                       cx_reg;
    mbe_pkg::coord_t                       cy_reg;
    mbe_pkg::coord_t                       zx_reg;
    mbe_pkg::coord_t                       zy_reg;
    mbe_pkg::coord_t                       zx2_reg;
    mbe_pkg::coord_t                       zy2_reg;
    mbe_pkg::pixel_out_t                   res_reg;
    logic                                  m_valid_reg;
    mbe_pkg::pixel_out_t                   m_data_reg;

    mbe_pkg::coord_t                       op_a;
    mbe_pkg::coord_t                       op_b;
    mbe_pkg::prod_t                        prod;
    mbe_pkg::coord_t                       prod_int;
    mbe_pkg::coord_t                       prod_sq;
    mbe_pkg::coord_t                       prod_xy2;
    logic [mbe_pkg::COORD_BITS:0]          mag_sum;
    logic                                  escaped;
    logic                                  pix_in_range;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pix_in_range = ({1'b0, s_data.pixel_x} < cfg.image_width) &&
                          ({1'b0, s_data.pixel_y} < cfg.image_height);

    // The product register is interpreted three ways depending on what was issued.
    assign prod_int = mbe_pkg::clamp_prod(prod);
    assign prod_sq  = mbe_pkg::clamp_prod(prod >>> mbe_pkg::FRAC_BITS);
    assign prod_xy2 = mbe_pkg::clamp_prod(prod >>> (mbe_pkg::FRAC_BITS - 1));

    // Squares are never negative, so the unsigned sum cannot wrap.
    assign mag_sum = {1'b0, zx2_reg} + {1'b0, prod_sq};
    assign escaped = (mag_sum >= mbe_pkg::ESCAPE_LIMIT);

    always_comb begin
        unique case (state_reg)
            S_CX: begin
                op_a = cfg.step_x;
                op_b = mbe_pkg::coord_t'({{(mbe_pkg::COORD_BITS-mbe_pkg::PIXEL_BITS){1'b0}},
                                          px_reg});
            end
            S_CY: begin
                op_a = cfg.step_y;
                op_b = mbe_pkg::coord_t'({{(mbe_pkg::COORD_BITS-mbe_pkg::PIXEL_BITS){1'b0}},
                                          py_reg});
            end
            S_XY: begin
                op_a = zx_reg;
                op_b = zy_reg;
            end
            S_SQX: begin
                op_a = zx_reg;
                op_b = zx_reg;
            end
            S_SQY: begin
                op_a = zy_reg;
                op_b = zy_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    mbe_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In S_FIN the output register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != S_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        px_reg    <= s_data.pixel_x;
                        py_reg    <= s_data.pixel_y;
                        limit_reg <= cfg.max_iterations;
                        iter_reg  <= '0;
                        zx_reg    <= '0;
                        zy_reg    <= '0;
                        zx2_reg   <= '0;
                        zy2_reg   <= '0;
                        res_reg.iteration_count <= '0;
                        res_reg.in_range        <= pix_in_range;
                        if (!pix_in_range || cfg.max_iterations == '0) begin
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_CX;
                        end
                    end
                end
                S_CX: begin
                    state_reg <= S_CY;
                end
                S_CY: begin
                    cx_reg    <= mbe_pkg::sat_add(cfg.win_left, prod_int);
                    state_reg <= S_CYW;
                end
                S_CYW: begin
                    cy_reg    <= mbe_pkg::sat_add(cfg.win_bottom, prod_int);
                    state_reg <= S_XY;
                end
                S_XY: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    zx_reg    <= mbe_pkg::sat_add(mbe_pkg::sat_sub(zx2_reg, zy2_reg), cx_reg);
                    zy_reg    <= mbe_pkg::sat_add(prod_xy2, cy_reg);
                    state_reg <= S_SQX;
                end
                S_SQX: begin
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    zx2_reg   <= prod_sq;
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    zy2_reg <= prod_sq;
                    if (escaped) begin
                        res_reg.iteration_count <= iter_reg;
                        state_reg <= S_FIN;
                    end else if (iter_reg == limit_reg - 1'b1) begin
                        res_reg.iteration_count <= limit_reg;
                        state_reg <= S_FIN;
                    end else begin
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_XY;
                    end
                end
                S_FIN: begin
                    // Wait here only while the previous result is still unclaimed.
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_iter_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_XY) |-> (iter_reg < limit_reg))
        else $error("iteration counter reached the limit inside the loop");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new pixel taken while one is in flight");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_range) |-> (m_data.iteration_count == '0))
        else $error("pixel outside the frame reported a nonzero count");

    a_square_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> !zx2_reg[mbe_pkg::COORD_BITS-1])
        else $error("squared magnitude term went negative");

endmodule

[hw/rtl/mandelbrot_escape_time.sv]
// Escape-time engine for one pixel at a time.
// Software sets the window origin, per-pixel steps, iteration limit and frame
// size through the cfg_* write port, which is always ready; the user must make
// writes only while no pixel is in flight, which the block itself does not enforce.
// A pixel beat on s_* gives one result beat on m_*. The point is c = origin +
// step * pixel, then z = z*z + c runs from zero until |z|^2 reaches 4.0 or the
// limit is hit; all arithmetic is saturating Q4.28. A single 32x32 multiplier
// with a registered product is shared by all steps, and each iteration uses it
// three times. After accept the sequencer steps through S_CX, S_CY and S_CYW,
// then runs the iteration loop for the escape count plus one passes, or for the
// limit if the point never escapes; pixels outside the frame and a zero limit go
// straight to S_FIN. s_ready is low for that whole time, so one pixel is processed at a time.
// Results sit in an output register: the next pixel is accepted while the
// previous result waits, and a finished pixel holds until m_ready frees that
// register. After aresetn the configuration registers hold their reset values
// and no result is pending.
module mandelbrot_escape_time (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mbe_pkg::pixel_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output mbe_pkg::pixel_out_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mbe_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    mbe_pkg::cfg_t cfg;

    mbe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbe_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
